FILE: rtl/dahfs_pkg.sv
// Shared types and constants of the Digest Authorization header field splitter.
`default_nettype none
package dahfs_pkg;

  // Parse phases of the header scanner.
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SCHEME = 3'd1,
    PH_POST   = 3'd2,
    PH_NAME   = 3'd3,
    PH_VALUE  = 3'd4,
    PH_SEP    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  // Field numbers in their fixed order.
  localparam logic [2:0] FLD_USER     = 3'd0;
  localparam logic [2:0] FLD_QOP      = 3'd4;
  localparam logic [2:0] FLD_NC       = 3'd5;
  localparam logic [2:0] FLD_RESPONSE = 3'd7;

  // Characters the scanner looks for.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Second quote closes a quoted value.
  localparam logic [1:0] QUOTE_CLOSE = 2'd2;

  // One result item.
  typedef struct packed {
    logic [2:0] field_id;
    logic [7:0] value_char;
    logic       char_valid;
    logic       header_done;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/dahfs_parser.sv
// Byte-wise header scanner: phase state and the result of each accepted byte.
`default_nettype none
module dahfs_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    header_byte,
  input  wire logic          last_byte,
  output logic               res_valid,
  output dahfs_pkg::res_t    res
);
  import dahfs_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] field_r, field_nxt;
  logic [1:0] qcnt_r, qcnt_nxt;
  logic       ws, emit;
  logic [1:0] qinc;

  assign ws   = (header_byte == CH_SPACE) ||
                ((header_byte >= CH_TAB) && (header_byte <= CH_CR));
  assign qinc = qcnt_r + 2'd1;

  // Next phase and the character to emit.
  always_comb begin
    phase_nxt = phase_r;
    field_nxt = field_r;
    qcnt_nxt  = qcnt_r;
    emit      = 1'b0;
    case (phase_r)
      PH_LEAD: begin
        if (!ws) phase_nxt = PH_SCHEME;
      end
      PH_SCHEME: begin
        if (ws) phase_nxt = PH_POST;
      end
      PH_POST, PH_SEP: begin
        if (!(ws || ((phase_r == PH_SEP) && (header_byte == CH_COMMA)))) begin
          // This byte already starts the name; '=' ends it at once.
          if (header_byte == CH_EQUAL) begin
            phase_nxt = PH_VALUE;
            qcnt_nxt  = 2'd0;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (ws || (header_byte == CH_EQUAL)) begin
          phase_nxt = PH_VALUE;
          qcnt_nxt  = 2'd0;
        end
      end
      PH_VALUE: begin
        if ((field_r != FLD_QOP) && (field_r != FLD_NC)) begin
          if (header_byte == CH_QUOTE) begin
            qcnt_nxt = qinc;
            if (qinc >= QUOTE_CLOSE) begin
              if (field_r == FLD_RESPONSE) begin
                phase_nxt = PH_DONE;
              end else begin
                field_nxt = field_r + 3'd1;
                phase_nxt = PH_SEP;
              end
            end
          end else begin
            emit = 1'b1;
          end
        end else begin
          if (ws || (header_byte == CH_COMMA)) begin
            if (field_r == FLD_RESPONSE) begin
              phase_nxt = PH_DONE;
            end else begin
              field_nxt = field_r + 3'd1;
              phase_nxt = PH_SEP;
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    // The last byte of a header returns the scanner to its start.
    if (last_byte) begin
      phase_nxt = PH_LEAD;
      field_nxt = FLD_USER;
      qcnt_nxt  = 2'd0;
    end
  end

  // Result of the current byte.
  always_comb begin
    res_valid        = emit || last_byte;
    res.field_id     = emit ? field_r : 3'd0;
    res.value_char   = emit ? header_byte : 8'd0;
    res.char_valid   = emit;
    res.header_done  = last_byte;
  end

  // Scanner state, updated on every accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      field_r <= FLD_USER;
      qcnt_r  <= 2'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      field_r <= field_nxt;
      qcnt_r  <= qcnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dahfs_out_buf.sv
// Result register with a skid entry that absorbs one result under output stall.
`default_nettype none
module dahfs_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dahfs_pkg::res_t push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dahfs_pkg::res_t    out_data
);
  import dahfs_pkg::*;

  logic main_valid_r, skid_valid_r;
  res_t main_r, skid_r;
  logic pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Valid bits of the two entries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) skid_valid_r <= 1'b0;
    end else if (push) begin
      if (!main_valid_r || pop) main_valid_r <= 1'b1;
      else                      skid_valid_r <= 1'b1;
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // Payload of the two entries.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (!main_valid_r || pop) main_r <= push_data;
      else                      skid_r <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/digest_auth_header_field_splitter.sv
// Top level of the Digest Authorization header field splitter.
//
//   channel  direction  handshake          payload
//   in_      request    in_valid/in_stall  in_header_byte, in_last_byte
//   out_     result     out_valid/out_stall out_field_id, out_value_char,
//                                          out_char_valid, out_header_done
//
// One header byte is accepted per cycle while in_stall is low; its result, if
// any, is registered at the output. The scan is a single registered pass.
// Synchronous active-low reset returns the scanner to the leading whitespace
// phase and empties the result register and skid entry.
// in_stall rises only when the skid entry is occupied by an untaken result.
`default_nettype none
module digest_auth_header_field_splitter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_header_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_field_id,
  output logic [7:0]      out_value_char,
  output logic            out_char_valid,
  output logic            out_header_done
);
  import dahfs_pkg::*;

  logic accept, res_valid, full;
  res_t res, out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Header scanner.
  dahfs_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .header_byte (in_header_byte),
    .last_byte   (in_last_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register and skid entry.
  dahfs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_field_id    = out_data.field_id;
  assign out_value_char  = out_data.value_char;
  assign out_char_valid  = out_data.char_valid;
  assign out_header_done = out_data.header_done;

endmodule
`default_nettype wire
